// ----- rtl/kmp_pkg.sv -----
package kmp_pkg;

	// sizes of the pattern memory and of the words
	localparam int PATTERN_MAX = 1024;
	localparam int WORD_BITS   = 32;
	localparam int IDX_W       = $clog2(PATTERN_MAX);
	localparam int LEN_W       = IDX_W + 1;
	localparam int COUNT_W     = 32;

	// operation codes of an input item
	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_TEXT   = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] word;
		logic        last;
	} item_t;

	typedef struct packed {
		logic               match;
		logic [COUNT_W-1:0] count;
		logic               run_end;
		logic               no_pattern;
	} result_t;

endpackage

// ----- rtl/kmp_stream_matcher.sv -----
// Knuth-Morris-Pratt matcher for a stream of 32-bit words.
// item channel (valid/ready): operation start or append loads a pattern word,
// operation text matches one text word; unused codes are dropped.
// result channel (valid/ready): one result per text word, none for loads.
// Sequencing from the item transfer:
//   start, append to an empty or full pattern, unused code: item_ready stays
//           high, so the next item can transfer in the following cycle
//   append: item_ready low while the chain is walked and the entry written
//   text:   result valid after the walk, plus a fallback step when a full
//           occurrence ends; empty pattern: no walk; item_ready returns as
//           the result loads
// The walk uses the single compare unit, one chain step per cycle through the
// pattern and failure memories (registered reads).
// item_ready is high only while the sequencer is idle; a result that waits in
// the output register does not stop the next item from being taken, but the
// sequencer holds before writing a new result until the receiver takes it.
// Reset clears the pattern length, match position and count; the memories
// need no clearing since only entries below the pattern length are read.
// A text word with last set ends the run: its result carries the final count
// and the match position and count return to zero afterwards.
module kmp_stream_matcher
	import kmp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_FB   = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0]           state_q;
	logic [LEN_W-1:0]     len_q;
	logic [LEN_W-1:0]     bp_q;
	logic [LEN_W-1:0]     mp_q;
	logic [COUNT_W-1:0]   cnt_q;
	logic [LEN_W-1:0]     k_q;
	logic [WORD_BITS-1:0] word_q;
	logic                 last_q;
	logic                 is_load_q;
	logic                 hit_q;

	logic                 accept;
	logic                 load_first;
	logic [LEN_W-1:0]     start_k;
	logic                 pat_eq;
	logic                 step_back;
	logic [LEN_W-1:0]     k_adv;
	logic [LEN_W-1:0]     k_next;
	logic [LEN_W-1:0]     f_addr_full;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [WORD_BITS-1:0] pat_wdata;
	logic [IDX_W-1:0]     fail_wdata;
	logic [WORD_BITS-1:0] pat_rdata;
	logic [IDX_W-1:0]     fail_rdata;
	logic                 out_free;
	logic                 emit;

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign load_first = accept && ((item.operation == OP_START) ||
		((item.operation == OP_APPEND) && (len_q == '0)));
	assign out_free   = !result_valid || result_ready;
	assign emit       = (state_q == S_EMIT) && out_free;

	// starting point of the chain walk for the incoming item
	always_comb begin
		if (item.operation == OP_TEXT) begin
			start_k = (mp_q >= len_q) ? '0 : mp_q;
		end else begin
			start_k = bp_q;
		end
	end

	// shared compare unit: one failure-chain step per cycle
	assign pat_eq    = (pat_rdata == word_q);
	assign step_back = (k_q != '0) && !pat_eq;
	assign k_adv     = k_q + LEN_W'(pat_eq);

	always_comb begin
		if (state_q == S_IDLE) begin
			k_next = start_k;
		end else if (step_back) begin
			k_next = LEN_W'(fail_rdata);
		end else begin
			k_next = k_adv;
		end
	end
	assign f_addr_full = k_next - LEN_W'(1);

	// memory write: first word straight from the item, others after the walk
	assign mem_we     = load_first || ((state_q == S_CMP) && !step_back && is_load_q);
	assign mem_waddr  = (state_q == S_IDLE) ? '0 : len_q[IDX_W-1:0];
	assign pat_wdata  = (state_q == S_IDLE) ? item.word[WORD_BITS-1:0] : word_q;
	assign fail_wdata = (state_q == S_IDLE) ? '0 : k_adv[IDX_W-1:0];

	kmp_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(PATTERN_MAX)
	) u_pat_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(pat_wdata),
		.raddr(k_next[IDX_W-1:0]),
		.rdata(pat_rdata)
	);

	kmp_ram #(
		.WIDTH(IDX_W),
		.DEPTH(PATTERN_MAX)
	) u_fail_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(fail_wdata),
		.raddr(f_addr_full[IDX_W-1:0]),
		.rdata(fail_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			len_q        <= '0;
			bp_q         <= '0;
			mp_q         <= '0;
			cnt_q        <= '0;
			result_valid <= 1'b0;
		end else begin
			// output register: set on a new result, clear after its transfer
			if (emit) begin
				result_valid <= 1'b1;
			end else if (result_valid && result_ready) begin
				result_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						word_q <= item.word[WORD_BITS-1:0];
						last_q <= item.last;
						k_q    <= start_k;
						hit_q  <= 1'b0;
						unique case (item.operation) inside
							OP_START, OP_APPEND: begin
								mp_q      <= '0;
								cnt_q     <= '0;
								is_load_q <= 1'b1;
								if (load_first) begin
									len_q <= LEN_W'(1);
									bp_q  <= '0;
								end else if (len_q != LEN_W'(PATTERN_MAX)) begin
									state_q <= S_CMP;
								end
							end
							OP_TEXT: begin
								is_load_q <= 1'b0;
								state_q   <= (len_q == '0) ? S_EMIT : S_CMP;
							end
							default: begin
							end
						endcase
					end
				end
				S_CMP: begin
					k_q <= k_next;
					if (!step_back) begin
						if (is_load_q) begin
							bp_q    <= k_adv;
							len_q   <= len_q + LEN_W'(1);
							state_q <= S_IDLE;
						end else if (k_adv >= len_q) begin
							hit_q   <= 1'b1;
							if (cnt_q != '1) begin
								cnt_q <= cnt_q + COUNT_W'(1);
							end
							state_q <= S_FB;
						end else begin
							mp_q    <= k_adv;
							state_q <= S_EMIT;
						end
					end
				end
				S_FB: begin
					mp_q    <= LEN_W'(fail_rdata);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit) begin
						result.match      <= hit_q;
						result.count      <= cnt_q;
						result.run_end    <= last_q;
						result.no_pattern <= (len_q == '0);
						if (last_q) begin
							mp_q  <= '0;
							cnt_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// pattern length never passes the memory depth
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(PATTERN_MAX))
		else $error("pattern length out of range");

	// build prefix stays a proper prefix of the loaded pattern
	a_bp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q != '0) |-> (bp_q < len_q))
		else $error("build prefix not below pattern length");

	// match position rests strictly inside the pattern
	a_mp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(mp_q == '0) || (mp_q < len_q))
		else $error("match position out of range");

	// chain walk only reads loaded entries
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (k_q < len_q))
		else $error("chain walk beyond pattern");

	// an empty pattern never reports a match
	a_no_pat_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.no_pattern) |-> !result.match)
		else $error("match reported without pattern");
`endif

endmodule

// ----- rtl/kmp_ram.sv -----
module kmp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- tb/sv/tb_kmp_stream_matcher.sv -----
`timescale 1ns / 1ps

module tb_kmp_stream_matcher;
	import kmp_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	// longest failure-chain walk plus the output stages
	localparam int TAIL_CYCLES = PATTERN_MAX + 64;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	kmp_stream_matcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	// items waiting to go out and match results still owed by the block
	item_t   items_to_send[$];
	result_t results_due[$];
	int      items_queued = 0;
	int      mismatch_count = 0;
	int      send_idle_pct = 0;
	int      recv_idle_pct = 0;
	int      recv_hold_req = 0;
	int      recv_hold_left = 0;
	bit      recv_hold_used = 1'b0;
	bit      item_taken = 1'b0;

	// shadow copy of the matcher state
	logic [31:0] pat_words [PATTERN_MAX];
	int unsigned fail_len [PATTERN_MAX];
	int unsigned pat_len = 0;
	int unsigned build_k = 0;
	int unsigned match_pos = 0;
	logic [31:0] run_count = '0;

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// longest border of the first p pattern words
	function automatic int unsigned border_of(int unsigned p);
		int unsigned f;
		f = fail_len[(p - 1) % PATTERN_MAX];
		return (f < p) ? f : 0;
	endfunction

	// step the shadow matcher by one item, queue the result a text word owes
	task automatic advance_matcher(input item_t it);
		logic [31:0] w;
		int unsigned k;
		result_t r;
		w = it.word;
		r = '0;
		case (it.operation) inside
			OP_START, OP_APPEND: begin
				if (it.operation == OP_START || pat_len == 0) begin
					pat_words[0] = w;
					fail_len[0] = 0;
					pat_len = 1;
					build_k = 0;
				end else if (pat_len < PATTERN_MAX) begin
					// extend the failure table by one entry
					k = build_k;
					while (k > 0 && pat_words[k % PATTERN_MAX] != w)
						k = border_of(k);
					if (pat_words[k % PATTERN_MAX] == w)
						k++;
					pat_words[pat_len] = w;
					fail_len[pat_len] = k;
					build_k = k;
					pat_len++;
				end
				// any load restarts the run
				match_pos = 0;
				run_count = '0;
			end
			OP_TEXT: begin
				if (pat_len != 0) begin
					k = (match_pos >= pat_len) ? 0 : match_pos;
					while (k > 0 && pat_words[k % PATTERN_MAX] != w)
						k = border_of(k);
					if (pat_words[k % PATTERN_MAX] == w)
						k++;
					if (k >= pat_len) begin
						r.match = 1'b1;
						if (run_count != '1)
							run_count++;
						k = border_of(k);
					end
					match_pos = k;
				end
				r.count = run_count;
				r.run_end = it.last;
				r.no_pattern = (pat_len == 0);
				results_due = {results_due, r};
				if (it.last) begin
					match_pos = 0;
					run_count = '0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		mismatch_count++;
		$display("%0t: %s: got %0h, want %0h", $time, what, got, want);
	endtask

	// predict on each item transfer, check each result transfer
	always @(posedge clk) begin
		result_t due;
		item_taken = item_valid && item_ready;
		if (arst_n) begin
			if (item_taken)
				advance_matcher(item);
			if (result_valid && result_ready) begin
				if (results_due.size() == 0) begin
					report_mismatch("result with none due", result.count, '0);
				end else begin
					due = results_due.pop_front();
					if (result.match !== due.match)
						report_mismatch("match", result.match, due.match);
					if (result.count !== due.count)
						report_mismatch("count", result.count, due.count);
					if (result.run_end !== due.run_end)
						report_mismatch("run_end", result.run_end, due.run_end);
					if (result.no_pattern !== due.no_pattern)
						report_mismatch("no_pattern", result.no_pattern, due.no_pattern);
				end
			end
		end
	end

	// item driver: hold until transfer, then maybe idle at random
	always @(negedge clk) begin
		if (!item_valid || item_taken) begin
			if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item <= items_to_send.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result receiver: random stalls plus a single long hold-off
	always @(negedge clk) begin
		if (recv_hold_req != 0 && !recv_hold_used) begin
			recv_hold_left = recv_hold_req;
			recv_hold_used = 1'b1;
		end
		if (recv_hold_left != 0) begin
			recv_hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic push_item(input logic [1:0] op, input logic [31:0] w, input logic l);
		item_t it;
		it.operation = op;
		it.word = w;
		it.last = l;
		items_to_send = {items_to_send, it};
		items_queued++;
	endtask

	task automatic wait_drained();
		while (items_to_send.size() != 0 || item_valid || results_due.size() != 0)
			@(posedge clk);
	endtask

	// pattern loads followed by text runs over a small alphabet, plus noise
	task automatic queue_traffic(input int n_items);
		int stop_at;
		int kind;
		int plen;
		int tlen;
		int asize;
		logic [31:0] alpha [3];
		stop_at = items_queued + n_items;
		foreach (alpha[i])
			alpha[i] = $urandom();
		asize = $urandom_range(1, 3);
		while (items_queued < stop_at) begin
			kind = $urandom_range(99);
			if (kind < 12) begin
				// noise: any code, any word, either last
				push_item(2'($urandom_range(3)), $urandom(), 1'($urandom_range(1)));
			end else begin
				// new pattern, an extended one, or the old one kept
				if (kind < 80) begin
					foreach (alpha[i])
						alpha[i] = $urandom();
					asize = $urandom_range(1, 3);
				end
				if (kind < 85) begin
					plen = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
					for (int i = 0; i < plen; i++)
						push_item((i == 0 && kind < 80) ? OP_START : OP_APPEND,
							alpha[$urandom_range(asize - 1)], 1'($urandom_range(1)));
				end
				tlen = $urandom_range(1, 48);
				for (int i = 0; i < tlen; i++) begin
					// a load in mid-run breaks the run
					if ($urandom_range(39) == 0)
						push_item(OP_APPEND, alpha[$urandom_range(asize - 1)],
							1'($urandom_range(1)));
					push_item(OP_TEXT,
						($urandom_range(15) == 0) ? $urandom() : alpha[$urandom_range(asize - 1)],
						(i == tlen - 1) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0));
				end
			end
		end
	endtask

	// main sequence
	initial begin
		logic [31:0] period_words [3];
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// empty pattern: held zero count, no_pattern set, last still echoed
		push_item(OP_TEXT, 32'h0000_0000, 1'b0);
		push_item(OP_TEXT, 32'hffff_ffff, 1'b1);
		// unused code is dropped
		push_item(OP_UNUSED, 32'h1234_5678, 1'b1);
		// append with no pattern starts one; last is ignored on loads
		push_item(OP_APPEND, 32'hffff_ffff, 1'b1);
		push_item(OP_APPEND, 32'h0000_0000, 1'b0);
		push_item(OP_APPEND, 32'hffff_ffff, 1'b1);
		// overlapping occurrences of f,0,f
		push_item(OP_TEXT, 32'hffff_ffff, 1'b0);
		push_item(OP_TEXT, 32'h0000_0000, 1'b0);
		push_item(OP_TEXT, 32'hffff_ffff, 1'b0);
		push_item(OP_UNUSED, 32'h0000_0000, 1'b0);
		push_item(OP_TEXT, 32'h0000_0000, 1'b0);
		push_item(OP_TEXT, 32'hffff_ffff, 1'b1);
		push_item(OP_TEXT, 32'h0000_0000, 1'b0);
		// a new pattern in mid-run restarts position and count
		push_item(OP_START, 32'h0000_0000, 1'b0);
		push_item(OP_TEXT, 32'h0000_0000, 1'b0);
		push_item(OP_TEXT, 32'h0000_0000, 1'b0);
		push_item(OP_APPEND, 32'h0000_0000, 1'b1);
		push_item(OP_TEXT, 32'h0000_0000, 1'b0);
		push_item(OP_TEXT, 32'h0000_0000, 1'b0);
		push_item(OP_TEXT, 32'h0000_0000, 1'b1);
		wait_drained();

		// rare sender gaps, frequent receiver stalls
		send_idle_pct = 6;
		recv_idle_pct = 74;
		queue_traffic(220);
		wait_drained();

		// frequent sender gaps, rare receiver stalls
		send_idle_pct = 74;
		recv_idle_pct = 6;
		queue_traffic(220);
		wait_drained();

		// full rate; the receiver holds off long enough to back up the input
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_traffic(220);
		recv_hold_req = 400;
		wait_drained();

		// fill the pattern store, then one more append that must be dropped
		foreach (period_words[i])
			period_words[i] = $urandom();
		for (int i = 0; i < PATTERN_MAX; i++)
			push_item((i == 0) ? OP_START : OP_APPEND, period_words[i % 3], 1'b0);
		push_item(OP_APPEND, ~period_words[0], 1'b1);
		// a short text with one break walks a long failure chain
		for (int i = 0; i < 64; i++)
			push_item(OP_TEXT, (i == 40) ? ~period_words[1] : period_words[i % 3],
				i == 63);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog
	initial begin
		#(10_000_000);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/kmp_pkg.sv
rtl/kmp_ram.sv
rtl/kmp_stream_matcher.sv
tb/sv/tb_kmp_stream_matcher.sv
